### hdl/ledpwm_pkg.sv
`timescale 1ns / 1ps

package ledpwm_pkg;

  // strip geometry
  localparam int MAX_PIXELS = 32;
  localparam int PIX_W      = $clog2(MAX_PIXELS);
  localparam int COLOR_W    = 24;
  localparam int BIT_W      = 5;
  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(COLOR_W - 1);

  // field widths
  localparam int DUTY_W  = 16;
  localparam int COUNT_W = 6;
  localparam int SLOTS_W = 8;
  localparam int INDEX_W = 5;
  localparam int CHAN_W  = 8;

  // configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // register reset values
  localparam logic [DUTY_W-1:0]  ONE_DUTY_RST    = 16'd58;
  localparam logic [DUTY_W-1:0]  ZERO_DUTY_RST   = 16'd29;
  localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 6'd30;
  localparam logic [SLOTS_W-1:0] RESET_SLOTS_RST = 8'd80;

  // register indexes
  typedef enum logic [1:0] {
    REG_ONE_DUTY    = 2'd0,
    REG_ZERO_DUTY   = 2'd1,
    REG_PIXEL_COUNT = 2'd2,
    REG_RESET_SLOTS = 2'd3
  } reg_idx_t;

  // command opcodes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_FILL    = 2'd1,
    OP_REFRESH = 2'd2,
    OP_TICK    = 2'd3
  } opcode_t;

  // refresh sequencer phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DATA  = 3'b010,
    PH_LATCH = 3'b100
  } phase_t;

endpackage

### hdl/ledpwm_cmd_if.sv
`timescale 1ns / 1ps

interface ledpwm_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [ledpwm_pkg::INDEX_W-1:0]  pixel_index;
  logic [ledpwm_pkg::CHAN_W-1:0]   red;
  logic [ledpwm_pkg::CHAN_W-1:0]   green;
  logic [ledpwm_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, opcode, pixel_index, red, green, blue, input ready);
  modport sink (input valid, opcode, pixel_index, red, green, blue, output ready);
endinterface

### hdl/ledpwm_slot_if.sv
`timescale 1ns / 1ps

interface ledpwm_slot_if;
  logic                           valid;
  logic                           ready;
  logic [ledpwm_pkg::DUTY_W-1:0]  duty;
  logic                           slot_valid;
  logic                           frame_done;
  logic                           busy_res;
  logic                           rejected;

  modport source (output valid, duty, slot_valid, frame_done, busy_res, rejected,
                  input ready);
  modport sink (input valid, duty, slot_valid, frame_done, busy_res, rejected,
                output ready);
endinterface

### hdl/rgb_led_strip_pwm_encoder.sv
`timescale 1ns / 1ps

// result: each transferred command's result is captured in the output register
// throughput: one command per cycle; ready holds while the output register is free
// or being taken in the same cycle, set by the single state update per command
// reset: clears the pixel store, the refresh sequencer and the valid flag of the output register,
// and loads the duty, pixel count and latch slot registers with their defaults
module rgb_led_strip_pwm_encoder (
  input  logic                            clk,
  input  logic                            rst,
  ledpwm_cmd_if.sink                      cmd,
  ledpwm_slot_if.source                   slot,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ledpwm_pkg::APB_AW-1:0]   paddr,
  input  logic [ledpwm_pkg::APB_DW-1:0]   pwdata,
  output logic [ledpwm_pkg::APB_DW-1:0]   prdata,
  output logic                            pready
);
  import ledpwm_pkg::*;

  // configuration registers
  logic [DUTY_W-1:0]  one_duty;
  logic [DUTY_W-1:0]  zero_duty;
  logic [COUNT_W-1:0] pixel_count;
  logic [SLOTS_W-1:0] reset_slots;

  // pixel store and sequencer state
  logic [COLOR_W-1:0] pixel_store [MAX_PIXELS];
  logic [PIX_W-1:0]   pixel_position, pixel_position_next;
  logic [BIT_W-1:0]   bit_position, bit_position_next;
  logic [SLOTS_W-1:0] latch_count, latch_count_next;
  phase_t             phase, phase_next;

  // output register
  logic               res_valid;
  logic [DUTY_W-1:0]  res_duty;
  logic               res_slot_valid;
  logic               res_frame_done;
  logic               res_busy;
  logic               res_rejected;

  logic               take;
  logic               cfg_write;
  reg_idx_t           cfg_idx;
  opcode_t            op;
  logic [COLOR_W-1:0] color;
  logic               busy;
  logic               store_write;
  logic               store_fill;
  logic [COLOR_W-1:0] word;
  logic [31:0]        word_ext;
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] pos_plus;
  logic [SLOTS_W:0]   latch_plus;
  logic [DUTY_W-1:0]  duty_c;
  logic               valid_c;
  logic               done_c;
  logic               rej_c;

  assign take      = cmd.valid && cmd.ready;
  assign cmd.ready = !res_valid || slot.ready;
  assign op        = opcode_t'(cmd.opcode);
  assign color     = {cmd.green, cmd.red, cmd.blue};
  assign busy      = (phase != PH_IDLE);

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      one_duty    <= ONE_DUTY_RST;
      zero_duty   <= ZERO_DUTY_RST;
      pixel_count <= PIXEL_COUNT_RST;
      reset_slots <= RESET_SLOTS_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_ONE_DUTY:    one_duty    <= pwdata[DUTY_W-1:0];
        REG_ZERO_DUTY:   zero_duty   <= pwdata[DUTY_W-1:0];
        REG_PIXEL_COUNT: pixel_count <= pwdata[COUNT_W-1:0];
        REG_RESET_SLOTS: reset_slots <= pwdata[SLOTS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ONE_DUTY:    prdata = APB_DW'(one_duty);
      REG_ZERO_DUTY:   prdata = APB_DW'(zero_duty);
      REG_PIXEL_COUNT: prdata = APB_DW'(pixel_count);
      REG_RESET_SLOTS: prdata = APB_DW'(reset_slots);
    endcase
  end

  // pixel count clamped to one..MAX_PIXELS
  always_comb begin
    if (pixel_count > COUNT_W'(MAX_PIXELS)) begin
      eff_count = COUNT_W'(MAX_PIXELS);
    end else if (pixel_count == '0) begin
      eff_count = COUNT_W'(1);
    end else begin
      eff_count = pixel_count;
    end
  end

  // current pixel word, bits above the color read as zero
  assign word       = (int'(pixel_position) < MAX_PIXELS) ? pixel_store[pixel_position] : '0;
  assign word_ext   = {(32 - COLOR_W)'(0), word};
  assign pos_plus   = COUNT_W'(pixel_position) + COUNT_W'(1);
  assign latch_plus = {1'b0, latch_count} + (SLOTS_W + 1)'(1);

  // command decode and sequencer step
  always_comb begin
    phase_next          = phase;
    pixel_position_next = pixel_position;
    bit_position_next   = bit_position;
    latch_count_next    = latch_count;
    duty_c              = '0;
    valid_c             = 1'b0;
    done_c              = 1'b0;
    rej_c               = 1'b0;
    store_write         = 1'b0;
    store_fill          = 1'b0;
    if (op != OP_TICK) begin
      if (busy) begin
        rej_c = 1'b1;
      end else begin
        unique case (op)
          OP_WRITE:   store_write = (int'(cmd.pixel_index) < MAX_PIXELS);
          OP_FILL:    store_fill  = 1'b1;
          OP_REFRESH: begin
            phase_next          = PH_DATA;
            pixel_position_next = '0;
            bit_position_next   = BIT_TOP;
            latch_count_next    = '0;
          end
          OP_TICK:    ;
        endcase
      end
    end else begin
      unique case (phase)
        PH_DATA: begin
          duty_c  = word_ext[bit_position] ? one_duty : zero_duty;
          valid_c = 1'b1;
          if (bit_position == '0 || bit_position > BIT_TOP) begin
            bit_position_next = BIT_TOP;
            if (pos_plus >= eff_count) begin
              pixel_position_next = '0;
              latch_count_next    = '0;
              if (reset_slots == '0) begin
                phase_next = PH_IDLE;
                done_c     = 1'b1;
              end else begin
                phase_next = PH_LATCH;
              end
            end else begin
              pixel_position_next = pos_plus[PIX_W-1:0];
            end
          end else begin
            bit_position_next = bit_position - BIT_W'(1);
          end
        end
        PH_LATCH: begin
          valid_c = 1'b1;
          if (latch_plus >= {1'b0, reset_slots}) begin
            latch_count_next = '0;
            phase_next       = PH_IDLE;
            done_c           = 1'b1;
          end else begin
            latch_count_next = latch_plus[SLOTS_W-1:0];
          end
        end
        PH_IDLE: ;
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      pixel_position <= '0;
      bit_position   <= BIT_TOP;
      latch_count    <= '0;
    end else if (take) begin
      phase          <= phase_next;
      pixel_position <= pixel_position_next;
      bit_position   <= bit_position_next;
      latch_count    <= latch_count_next;
    end
  end

  // pixel store: single write, or fill of every entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXELS; i++) begin
        pixel_store[i] <= '0;
      end
    end else if (take && store_fill) begin
      for (int i = 0; i < MAX_PIXELS; i++) begin
        pixel_store[i] <= color;
      end
    end else if (take && store_write) begin
      pixel_store[cmd.pixel_index[PIX_W-1:0]] <= color;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (slot.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_duty       <= duty_c;
      res_slot_valid <= valid_c;
      res_frame_done <= done_c;
      res_busy       <= (phase_next != PH_IDLE);
      res_rejected   <= rej_c;
    end
  end

  assign slot.valid      = res_valid;
  assign slot.duty       = res_duty;
  assign slot.slot_valid = res_slot_valid;
  assign slot.frame_done = res_frame_done;
  assign slot.busy_res   = res_busy;
  assign slot.rejected   = res_rejected;

  // a data slot never points past the top color bit
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bit_position <= BIT_TOP)
    else $error("bit position out of range during data phase");

  // a refresh accepted while idle starts the data phase
  a_refresh_start: assert property (@(posedge clk) disable iff (rst)
    take && op == OP_REFRESH && phase == PH_IDLE |=> phase == PH_DATA)
    else $error("refresh did not start the data phase");

  // a result is never both a slot and a refusal
  a_slot_or_reject: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_slot_valid && res_rejected))
    else $error("result marked as slot and rejected");

  // end of frame leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    take && done_c |=> phase == PH_IDLE && !res_busy)
    else $error("frame done but sequencer still busy");

  // latch phase runs with the pixel pointer parked at zero
  a_latch_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LATCH |-> pixel_position == '0)
    else $error("pixel pointer not cleared in latch phase");

endmodule
